// File: design/rps_pkg.sv
// Shared types and constants for the radius pair search block.
// No dependencies; every other design file except rps_if imports this package.
`default_nettype none
package rps_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int OUT_IDX_W  = 6;
  localparam int TOTAL_W    = 11;
  localparam int LIMIT_W    = 23;
  localparam int LIM2_W     = 2 * LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd65536;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 11'd2047;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [15:0]        sid;
  } point_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] index_a;
    logic [OUT_IDX_W-1:0] index_b;
    logic [TOTAL_W-1:0]   pair_total;
    logic                 last;
    logic                 overflow;
  } result_t;

endpackage
`default_nettype wire

// File: design/rps_if.sv
// Valid/ready channel interfaces for the point input and the pair results.
// Depends on nothing.
`default_nettype none
interface rps_in_if;
  logic               valid;
  logic               ready;
  logic               start_set;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [15:0]        surface_id;

  modport source(output valid, start_set, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                 surface_id, input ready);
  modport sink(input valid, start_set, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
               surface_id, output ready);
endinterface

interface rps_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  index_a;
  logic [5:0]  index_b;
  logic [10:0] pair_total;
  logic        last;
  logic        overflow;

  modport source(output valid, index_a, index_b, pair_total, last, overflow, input ready);
  modport sink(input valid, index_a, index_b, pair_total, last, overflow, output ready);
endinterface
`default_nettype wire

// File: design/radius_pair_search_3d.sv
// Top level of the fixed-radius 3D pair search.
// Depends on rps_pkg, rps_if, rps_cell and rps_cmp.
// -----------------------------------------------------------------------------
// Points arrive on in_ch, one transaction per point. A point with start_set
// high clears the stored set and the pair count before it is handled. Each
// point is tested against every stored point of the set in ascending index;
// each qualifying pair leaves on out_ch as one transaction, the final one of a
// point carrying last. A point that finds the store full is dropped and gives
// one transaction with overflow and last set.
// Stored points live in a ring of MAX_POINTS cells that rotates toward cell 0,
// where the shared four-stage pair tester reads them. Candidates are issued to
// the tester one by one and decided on its verdict; then the ring rotates back
// to its home position before the new point is written. in_ch is ready only
// between points. Results pass through a pending register and one output
// register, so the search keeps going while a result waits; a stalled receiver
// holds the search only when a result must move into the full output register.
// The distance limit must be written on cfg_we/cfg_wdata only while idle; the
// block does not enforce this. Reset is synchronous: it empties the set, clears
// the count and restores the limit to 1.0; stored point data is not cleared.
// -----------------------------------------------------------------------------
`default_nettype none
module radius_pair_search_3d
  import rps_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  rps_in_if.sink                   in_ch,
  rps_out_if.source                out_ch,
  input  wire logic                cfg_we,
  input  wire logic [LIMIT_W-1:0]  cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ISSUE  = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_ROT    = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;
  localparam logic [2:0] S_OVF    = 3'd6;

  logic [2:0]         state_r;
  logic [1:0]         wait_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   rot_r;
  logic [TOTAL_W-1:0] pairs_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [LIM2_W-1:0]  lim2_r;
  point_t             new_r;
  logic               qual_hold_r;

  logic    pend_v_r;
  result_t pend_r;
  logic    out_v_r;
  result_t out_r;

  point_t cells [MAX_POINTS];
  logic   shift;
  logic   load;
  logic   qual;
  logic   qual_use;
  logic   push;
  logic   can_push;
  logic   accept;
  logic [CNT_W-1:0]   cnt_eff;
  logic [TOTAL_W-1:0] pairs_eff;
  logic [TOTAL_W-1:0] pairs_inc;
  point_t             in_pt;

  assign in_pt = '{px: in_ch.pos_x, py: in_ch.pos_y, pz: in_ch.pos_z,
                   nx: in_ch.norm_x, ny: in_ch.norm_y, nz: in_ch.norm_z,
                   sid: in_ch.surface_id};

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign cnt_eff     = in_ch.start_set ? '0 : cnt_r;
  assign pairs_eff   = in_ch.start_set ? '0 : pairs_r;
  assign pairs_inc   = (pairs_r == TOTAL_MAX) ? pairs_r : pairs_r + 1'b1;
  assign can_push    = !out_v_r || out_ch.ready;

  // The tester keeps running while the decision waits, so its verdict is
  // taken on the first decision cycle and held for any cycles after it.
  assign qual_use = (wait_r == 2'd3) ? qual : qual_hold_r;

  // A result moves into the output register in this cycle.
  assign push = ((state_r == S_DECIDE) && qual_use && pend_v_r && can_push) ||
                ((state_r == S_FLUSH) && pend_v_r && can_push) ||
                ((state_r == S_OVF) && can_push);

  // The ring rotates once per issued candidate and in the return sweep.
  assign shift = (state_r == S_ISSUE) ||
                 ((state_r == S_ROT) && (rot_r != CNT_W'(MAX_POINTS)));
  assign load  = (state_r == S_ROT) && (rot_r == CNT_W'(MAX_POINTS));

  for (genvar j = 0; j < MAX_POINTS; j++) begin : g_ring
    rps_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .load     (load && (cnt_r[IDX_W-1:0] == IDX_W'(j))),
      .load_pt  (new_r),
      .from_next(cells[(j + 1) % MAX_POINTS]),
      .pt       (cells[j])
    );
  end

  rps_cmp u_cmp (
    .clk (clk),
    .a   (cells[0]),
    .b   (new_r),
    .lim2(lim2_r),
    .qual(qual)
  );

  always_ff @(posedge clk) begin
    lim2_r <= LIM2_W'(limit_r) * LIM2_W'(limit_r);
    if (accept) begin
      new_r <= in_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      rot_r       <= '0;
      pairs_r     <= '0;
      qual_hold_r <= 1'b0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (out_v_r && out_ch.ready && !push) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cnt_r   <= cnt_eff;
            pairs_r <= pairs_eff;
            idx_r   <= '0;
            rot_r   <= '0;
            if (cnt_eff == CNT_W'(MAX_POINTS)) begin
              state_r <= S_OVF;
            end else if (cnt_eff == '0) begin
              state_r <= S_ROT;
            end else begin
              state_r <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          rot_r   <= rot_r + 1'b1;
          wait_r  <= '0;
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          wait_r <= wait_r + 1'b1;
          if (wait_r == 2'd2) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          wait_r      <= '0;
          qual_hold_r <= qual_use;
          if (!qual_use || !pend_v_r || can_push) begin
            if (qual_use) begin
              if (pend_v_r) begin
                out_v_r <= 1'b1;
                out_r   <= pend_r;
              end
              pend_v_r          <= 1'b1;
              pend_r.index_a    <= OUT_IDX_W'(idx_r);
              pend_r.index_b    <= OUT_IDX_W'(cnt_r);
              pend_r.pair_total <= pairs_inc;
              pend_r.last       <= 1'b0;
              pend_r.overflow   <= 1'b0;
              pairs_r           <= pairs_inc;
            end
            idx_r <= idx_r + 1'b1;
            if (idx_r + 1'b1 == cnt_r) begin
              state_r <= S_ROT;
            end else begin
              state_r <= S_ISSUE;
            end
          end
        end
        S_ROT: begin
          if (load) begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_FLUSH;
          end else begin
            rot_r <= rot_r + 1'b1;
          end
        end
        S_FLUSH: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (can_push) begin
            out_v_r     <= 1'b1;
            out_r       <= '{index_a: pend_r.index_a, index_b: pend_r.index_b,
                             pair_total: pend_r.pair_total, last: 1'b1,
                             overflow: pend_r.overflow};
            pend_v_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_OVF: begin
          if (can_push) begin
            out_v_r          <= 1'b1;
            out_r.index_a    <= '0;
            out_r.index_b    <= '0;
            out_r.pair_total <= pairs_r;
            out_r.last       <= 1'b1;
            out_r.overflow   <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.index_a    = out_r.index_a;
  assign out_ch.index_b    = out_r.index_b;
  assign out_ch.pair_total = out_r.pair_total;
  assign out_ch.last       = out_r.last;
  assign out_ch.overflow   = out_r.overflow;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("stored point count beyond capacity");

  a_issue_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) |-> (idx_r < cnt_r))
    else $error("candidate issued past the stored set");

  a_decide_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |->
      ($past(state_r) == S_WAIT || $past(state_r) == S_DECIDE))
    else $error("decision taken before the tester pipeline drained");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("pending pair left behind between points");

endmodule
`default_nettype wire

// File: design/rps_cell.sv
// One storage cell of the rotating point ring.
// Depends on rps_pkg for point_t.
`default_nettype none
module rps_cell
  import rps_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   shift,
  input  wire logic   load,
  input  wire point_t load_pt,
  input  wire point_t from_next,
  output point_t      pt
);

  point_t pt_r;

  always_ff @(posedge clk) begin
    if (load) begin
      pt_r <= load_pt;
    end else if (shift) begin
      pt_r <= from_next;
    end
  end

  assign pt = pt_r;

endmodule
`default_nettype wire

// File: design/rps_cmp.sv
// Four-stage pair test: squared distance against the limit, surface ids and
// the opposing-normal test. Depends on rps_pkg.
`default_nettype none
module rps_cmp
  import rps_pkg::*;
(
  input  wire logic              clk,
  input  wire point_t            a,
  input  wire point_t            b,
  input  wire logic [LIM2_W-1:0] lim2,
  output logic                   qual
);

  logic signed [24:0] dx, dy, dz;
  logic signed [49:0] sqx, sqy, sqz;
  logic signed [31:0] ndx, ndy, ndz, nax, nay, naz, nbx, nby, nbz;

  logic [49:0]        sqx_r, sqy_r, sqz_r;
  logic signed [31:0] ndx_r, ndy_r, ndz_r;
  logic [31:0]        nax_r, nay_r, naz_r, nbx_r, nby_r, nbz_r;
  logic               ne1_r;

  logic [51:0]        s_r;
  logic signed [33:0] dot_r;
  logic [31:0]        ma_r, mb_r;
  logic               ne2_r;

  logic [31:0]        ad;
  logic [63:0]        dd_r, mm_r;
  logic               neg_r, near_r, ne3_r;
  logic               qual_r;

  assign dx  = {b.px[23], b.px} - {a.px[23], a.px};
  assign dy  = {b.py[23], b.py} - {a.py[23], a.py};
  assign dz  = {b.pz[23], b.pz} - {a.pz[23], a.pz};
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign sqz = dz * dz;
  assign ndx = a.nx * b.nx;
  assign ndy = a.ny * b.ny;
  assign ndz = a.nz * b.nz;
  assign nax = a.nx * a.nx;
  assign nay = a.ny * a.ny;
  assign naz = a.nz * a.nz;
  assign nbx = b.nx * b.nx;
  assign nby = b.ny * b.ny;
  assign nbz = b.nz * b.nz;

  assign ad = dot_r[33] ? 32'(-dot_r) : 32'(dot_r);

  always_ff @(posedge clk) begin
    sqx_r <= 50'(sqx);
    sqy_r <= 50'(sqy);
    sqz_r <= 50'(sqz);
    ndx_r <= ndx;
    ndy_r <= ndy;
    ndz_r <= ndz;
    nax_r <= 32'(nax);
    nay_r <= 32'(nay);
    naz_r <= 32'(naz);
    nbx_r <= 32'(nbx);
    nby_r <= 32'(nby);
    nbz_r <= 32'(nbz);
    ne1_r <= (a.sid != b.sid);

    s_r   <= {2'b00, sqx_r} + {2'b00, sqy_r} + {2'b00, sqz_r};
    dot_r <= 34'(ndx_r) + 34'(ndy_r) + 34'(ndz_r);
    ma_r  <= nax_r + nay_r + naz_r;
    mb_r  <= nbx_r + nby_r + nbz_r;
    ne2_r <= ne1_r;

    dd_r   <= 64'(ad) * 64'(ad);
    mm_r   <= 64'(ma_r) * 64'(mb_r);
    neg_r  <= dot_r[33];
    near_r <= (s_r < 52'(lim2));
    ne3_r  <= ne2_r;

    qual_r <= near_r && (ne3_r || (neg_r && (dd_r > (mm_r >> 2))));
  end

  assign qual = qual_r;

endmodule
`default_nettype wire

// File: dv/radius_pair_search_3d_test.sv
// Self-checking testbench for the fixed-radius 3D pair search block.
// Depends on rps_pkg, the channel interfaces in rps_if and radius_pair_search_3d.
`default_nettype none
module radius_pair_search_3d_test;
  import rps_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  rps_in_if in_ch();
  rps_out_if out_ch();

  radius_pair_search_3d dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: a copy of the stored set and the running pair count.
  logic signed [23:0] set_pos [0:MAX_POINTS-1][0:2];
  logic signed [15:0] set_norm [0:MAX_POINTS-1][0:2];
  logic [15:0] set_sid [0:MAX_POINTS-1];
  int unsigned set_size;
  int unsigned pairs_so_far;
  logic [LIMIT_W-1:0] radius;

  result_t pending_pairs[$];
  int unsigned mismatches;
  int unsigned items_sent;

  logic sink_stall_on;
  logic no_idle;
  logic long_hold;

  // Cosine below -0.5 between two normals, done without a square root.
  function automatic logic normals_face(input logic signed [15:0] a [0:2],
                                        input logic signed [15:0] b [0:2]);
    longint dot, ma, mb;
    logic [127:0] lhs, rhs;
    dot = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
    if (dot >= 0) return 1'b0;
    ma = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
    mb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
    lhs = 128'(-dot) * 128'(-dot) * 4;
    rhs = 128'(ma) * 128'(mb);
    return lhs > rhs;
  endfunction

  // Works out the pairs that one accepted point produces, then stores it.
  task automatic predict_pairs(input point_t p, input logic start);
    logic signed [15:0] nn [0:2];
    logic signed [23:0] pp [0:2];
    longint dist2, d;
    longint lim2;
    result_t r;
    int found;
    found = 0;
    pp[0] = p.px; pp[1] = p.py; pp[2] = p.pz;
    nn[0] = p.nx; nn[1] = p.ny; nn[2] = p.nz;
    lim2 = longint'(radius) * longint'(radius);
    if (start) begin
      set_size = 0;
      pairs_so_far = 0;
    end
    if (set_size >= MAX_POINTS) begin
      r = '{index_a: '0, index_b: '0, pair_total: pairs_so_far[10:0],
            last: 1'b1, overflow: 1'b1};
      pending_pairs.push_back(r);
      return;
    end
    for (int i = 0; i < set_size; i++) begin
      dist2 = 0;
      for (int k = 0; k < 3; k++) begin
        d = longint'(pp[k]) - longint'(set_pos[i][k]);
        dist2 += d * d;
      end
      if (dist2 < lim2 && (set_sid[i] != p.sid || normals_face(set_norm[i], nn))) begin
        if (pairs_so_far < 2047) pairs_so_far++;
        r = '{index_a: i[5:0], index_b: set_size[5:0],
              pair_total: pairs_so_far[10:0], last: 1'b0, overflow: 1'b0};
        pending_pairs.push_back(r);
        found++;
      end
    end
    if (found > 0) pending_pairs[pending_pairs.size()-1].last = 1'b1;
    for (int k = 0; k < 3; k++) begin
      set_pos[set_size][k] = pp[k];
      set_norm[set_size][k] = nn[k];
    end
    set_sid[set_size] = p.sid;
    set_size++;
  endtask

  // The input channel is driven from this point register and start flag.
  point_t drive_pt;
  logic drive_start;
  always_comb begin
    in_ch.start_set = drive_start;
    in_ch.pos_x = drive_pt.px;
    in_ch.pos_y = drive_pt.py;
    in_ch.pos_z = drive_pt.pz;
    in_ch.norm_x = drive_pt.nx;
    in_ch.norm_y = drive_pt.ny;
    in_ch.norm_z = drive_pt.nz;
    in_ch.surface_id = drive_pt.sid;
  end

  // Every accepted result transaction is compared with the oldest expected pair.
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{index_a: out_ch.index_a, index_b: out_ch.index_b,
              pair_total: out_ch.pair_total, last: out_ch.last,
              overflow: out_ch.overflow};
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_pairs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    int burst;
    logic hold_done;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
      end else if (sink_stall_on && !no_idle && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 5);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Sends one point and waits for its acceptance; the prediction runs at the
  // accepting edge, so configuration and state are those seen by the block.
  task automatic send_point(input point_t p, input logic start, input logic gaps);
    if (gaps && !no_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    drive_pt <= p;
    drive_start <= start;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_pairs(p, start);
    items_sent++;
  endtask

  // Waits until every expected result is in, plus the block's settling time.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_radius(input logic [LIMIT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius = v;
  endtask

  function automatic point_t rand_point(input int spread, input int nspread);
    point_t p;
    p.px = 24'($signed($urandom_range(0, 2*spread)) - spread);
    p.py = 24'($signed($urandom_range(0, 2*spread)) - spread);
    p.pz = 24'($signed($urandom_range(0, 2*spread)) - spread);
    p.nx = 16'($signed($urandom_range(0, 2*nspread)) - nspread);
    p.ny = 16'($signed($urandom_range(0, 2*nspread)) - nspread);
    p.nz = 16'($signed($urandom_range(0, 2*nspread)) - nspread);
    p.sid = 16'($urandom_range(0, 2));
    return p;
  endfunction

  function automatic point_t wild_point();
    point_t p;
    p.px = 24'($urandom()); p.py = 24'($urandom()); p.pz = 24'($urandom());
    p.nx = 16'($urandom()); p.ny = 16'($urandom()); p.nz = 16'($urandom());
    p.sid = 16'($urandom());
    return p;
  endfunction

  // Directed rows: start flag, point, and for the obvious rows the one result.
  typedef struct {
    logic   start;
    point_t pt;
    logic   has_fixed;
    result_t fixed;
  } row_t;

  row_t rows [$];

  task automatic add_row(input logic s, input point_t p);
    row_t r;
    r.start = s; r.pt = p; r.has_fixed = 1'b0; r.fixed = '0;
    rows.push_back(r);
  endtask

  initial begin
    point_t p;
    int phase;
    in_ch.valid = 1'b0;
    drive_pt = '0;
    drive_start = 1'b0;
    set_size = 0;
    pairs_so_far = 0;
    radius = LIMIT_RESET;
    mismatches = 0;
    items_sent = 0;
    sink_stall_on = 1'b0;
    no_idle = 1'b0;
    long_hold = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset radius of 1.0.
    // Same surface, identical normals: no pair; different surface: a pair.
    add_row(1'b1, '{px: 0, py: 0, pz: 0, nx: 16384, ny: 0, nz: 0, sid: 7});
    add_row(1'b0, '{px: 100, py: 0, pz: 0, nx: 16384, ny: 0, nz: 0, sid: 7});
    add_row(1'b0, '{px: 0, py: 200, pz: 0, nx: 0, ny: 0, nz: 0, sid: 8});
    // Same surface with opposing normals pairs; a zero normal never opposes.
    add_row(1'b0, '{px: 5, py: 5, pz: 5, nx: -16384, ny: 0, nz: 0, sid: 7});
    add_row(1'b0, '{px: 9, py: 1, pz: 2, nx: 0, ny: 0, nz: 0, sid: 7});
    // Exactly at the radius does not qualify, one below does.
    add_row(1'b1, '{px: 0, py: 0, pz: 0, nx: 1, ny: 1, nz: 1, sid: 0});
    add_row(1'b0, '{px: 65536, py: 0, pz: 0, nx: 1, ny: 1, nz: 1, sid: 1});
    add_row(1'b0, '{px: 0, py: 65535, pz: 0, nx: 1, ny: 1, nz: 1, sid: 1});
    // 120 degree boundary: a cosine above -0.5 fails, one below it passes.
    add_row(1'b1, '{px: 0, py: 0, pz: 0, nx: 2, ny: 0, nz: 0, sid: 3});
    add_row(1'b0, '{px: 0, py: 0, pz: 0, nx: -1, ny: 0, nz: 2, sid: 3});
    add_row(1'b0, '{px: 0, py: 0, pz: 1, nx: -32768, ny: -32768, nz: -32768, sid: 3});
    add_row(1'b0, '{px: 0, py: 0, pz: 2, nx: 32767, ny: 32767, nz: 32767, sid: 3});
    // Extremes of every field.
    add_row(1'b1, '{px: -8388608, py: -8388608, pz: -8388608,
                    nx: -32768, ny: 32767, nz: -32768, sid: 65535});
    add_row(1'b0, '{px: 8388607, py: 8388607, pz: 8388607,
                    nx: 32767, ny: -32768, nz: 32767, sid: 0});
    foreach (rows[i]) send_point(rows[i].pt, rows[i].start, 1'b0);
    drain();

    // A first point after a new set start has nothing to pair with; the single
    // transaction of a full store is known in advance and typed in here.
    rows.delete();
    sink_stall_on = 1'b1;
    write_radius(23'd1);
    add_row(1'b1, '{px: 3, py: 3, pz: 3, nx: 0, ny: 0, nz: 0, sid: 1});
    for (int i = 1; i < MAX_POINTS; i++)
      add_row(1'b0, '{px: 3, py: 3, pz: 3, nx: 0, ny: 0, nz: 0, sid: 1});
    add_row(1'b0, '{px: 3, py: 3, pz: 3, nx: 0, ny: 0, nz: 0, sid: 2});
    rows[MAX_POINTS].has_fixed = 1'b1;
    rows[MAX_POINTS].fixed = '{index_a: 0, index_b: 0, pair_total: 0,
                               last: 1'b1, overflow: 1'b1};
    foreach (rows[i]) begin
      send_point(rows[i].pt, rows[i].start, 1'b1);
      if (rows[i].has_fixed && pending_pairs.size() != 0
          && pending_pairs[pending_pairs.size()-1] !== rows[i].fixed) begin
        mismatches++;
        if (mismatches <= 10) $display("full store prediction off for row %0d", i);
      end
    end
    drain();

    // Random sets over several radii. A dense cluster at the largest radius
    // pushes the pair count toward saturation; the long hold-off fills the block.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_radius(23'd8388607);
        1: write_radius(23'd65536);
        2: write_radius(23'd300000);
        3: write_radius(23'd4000);
        4: write_radius(23'd1);
        default: write_radius(23'd200000);
      endcase
      if (phase == 5) no_idle = 1'b1;
      for (int n = 0; n < 58; n++) begin
        if (phase == 1 && n == 10) long_hold = 1'b1;
        if ($urandom_range(0, 9) == 0) p = wild_point();
        else p = rand_point(phase == 3 ? 8000 : 150000, 20000);
        send_point(p, n == 0 || $urandom_range(0, 24) == 0, 1'b1);
      end
      drain();
    end
  end

  // Overall limit, far above the slowest legal run.
  initial begin
    #20000000;
    $display("radius_pair_search_3d_test NOT OK");
    $finish;
  end

  // Ends the run once the stimulus process has drained its last phase.
  initial begin
    @(posedge rst_n);
    wait (no_idle === 1'b1);
    wait (items_sent >= 14 + MAX_POINTS + 1 + 6 * 58);
    @(posedge clk);
    while (pending_pairs.size() != 0 || in_ch.valid) @(posedge clk);
    repeat (500) @(posedge clk);
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("radius_pair_search_3d_test OK");
    end else begin
      $display("radius_pair_search_3d_test NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
design/rps_pkg.sv
design/rps_if.sv
design/rps_cell.sv
design/rps_cmp.sv
design/radius_pair_search_3d.sv
dv/radius_pair_search_3d_test.sv
